// ===== hw/rtl/lilm_pkg.sv =====
package lilm_pkg;

    localparam int NUM_LINES  = 32;
    localparam int LEVEL_W    = 3;
    localparam int CPU_IDX_W  = 2;
    localparam int LINE_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // command codes
    localparam logic [1:0] CMD_SET_LEVEL = 2'd0;
    localparam logic [1:0] CMD_INTERRUPT = 2'd1;
    localparam logic [1:0] CMD_REGISTER  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_LEVEL    = 2'd0;
    localparam logic [1:0] KIND_ACK      = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;
    localparam logic [1:0] KIND_REGISTER = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_CPU = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 3'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [CPU_IDX_W-1:0] cpu_index;
        logic [LEVEL_W-1:0]   new_level;
        logic                 lowering;
        logic [31:0]          hw_word;
        logic [LINE_W-1:0]    line_index;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [LEVEL_W-1:0] prev_level;
        logic               cpu_int_enable;
        logic               fake_interrupt;
        logic               mask_write;
        logic [31:0]        mask_value;
        logic [31:0]        clear_value;
        logic [LINE_W-1:0]  dispatch_line;
        logic               line_registered;
        logic               status;
        logic               last;
    } result_t;

endpackage

// ===== hw/rtl/lazy_interrupt_level_masker_core.sv =====
// Lazy interrupt level masker.
// Command channel: an item (struct lilm_pkg::item_t) transfers on a clock edge with
// start high and busy low. Commands: set level, interrupt event, register line;
// the unused command code is taken and dropped.
// Results (lilm_pkg::result_t) appear for one cycle each with result_valid high;
// the receiver always takes them, there is no back-pressure. The final result of
// a command carries last.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while the block is idle.
// Steps, command to first result:
//   register line: result directly if rejected or nothing to mark, else after
//     a sweep of the level mask memory, one entry a cycle, top level down.
//   set level: processor level memory read, then level mask read, then result.
//   interrupt: acknowledge, then one dispatch per cycle.
// busy drops as the final result is registered, so the next command can follow.
// Reset: all masks, lines and levels clear, master 0, threshold 2. Both memories
// carry per-entry valid bits cleared by reset, so no clearing pass is needed.
module lazy_interrupt_level_masker_core #(
    parameter int NUM_LEVELS = 8,
    parameter int NUM_CPUS   = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lilm_pkg::item_t                     item,
    output logic                                result_valid,
    output lilm_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lilm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lilm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LVL_W = $clog2(NUM_LEVELS);
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int NL    = lilm_pkg::NUM_LINES;
    localparam int LW    = lilm_pkg::LINE_W;
    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(NUM_LEVELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LV_RD,
        S_LV_TBL,
        S_REG_WR,
        S_DISP
    } state_t;

    // memories
    logic [NL-1:0] tbl_mem [NUM_LEVELS];
    logic [NL-1:0] tbl_rdata;
    logic          tbl_re, tbl_we;
    logic [LVL_W-1:0] tbl_raddr, tbl_waddr;
    logic [NL-1:0] tbl_wdata;

    logic [2:0]    cpu_mem [NUM_CPUS];
    logic [2:0]    cpu_rdata;
    logic          cpu_re, cpu_we;
    logic [CPU_W-1:0] cpu_raddr, cpu_waddr;
    logic [2:0]    cpu_wdata;

    // registers
    state_t            state_reg, state_next;
    lilm_pkg::item_t   item_reg, item_next;
    logic [2:0]        oldl_reg, oldl_next;
    logic [2:0]        lvl_reg, lvl_next;
    logic [LVL_W-1:0]  addr_reg, addr_next;
    logic [NL-1:0]     irq_reg, irq_next;
    logic [NL-1:0]     line_taken_reg, line_taken_next;
    logic [NL-1:0]     pending_reg, pending_next;
    logic [NL-1:0]     desired_reg, desired_next;
    logic [NL-1:0]     current_reg, current_next;
    logic [NUM_LEVELS-1:0] tbl_vld_reg, tbl_vld_next;
    logic [NUM_CPUS-1:0]   cpu_vld_reg, cpu_vld_next;
    logic [1:0]        master_reg, master_next;
    logic [2:0]        thresh_reg, thresh_next;
    lilm_pkg::result_t result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    function automatic logic [2:0] clamp_level(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        if (int'(v) >= NUM_LEVELS) begin
            r = 3'(NUM_LEVELS - 1);
        end
        return r;
    endfunction

    // highest set bit
    function automatic logic [LW-1:0] top_bit(input logic [NL-1:0] v);
        logic [LW-1:0] pos;
        pos = '0;
        for (int i = 0; i < NL; i++) begin
            if (v[i]) begin
                pos = LW'(i);
            end
        end
        return pos;
    endfunction

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        logic [2:0]    lvl;
        logic [2:0]    old;
        logic [NL-1:0] bit_sel;
        logic [NL-1:0] irq;
        logic [NL-1:0] pend;
        logic [NL-1:0] wanted;
        logic [NL-1:0] tdata;
        logic [NL-1:0] rest;
        logic [LW-1:0] top;
        logic          mw;
        logic          en;
        logic          fake;

        state_next        = state_reg;
        item_next         = item_reg;
        oldl_next         = oldl_reg;
        lvl_next          = lvl_reg;
        addr_next         = addr_reg;
        irq_next          = irq_reg;
        line_taken_next   = line_taken_reg;
        pending_next      = pending_reg;
        desired_next      = desired_reg;
        current_next      = current_reg;
        tbl_vld_next      = tbl_vld_reg;
        cpu_vld_next      = cpu_vld_reg;
        master_next       = master_reg;
        thresh_next       = thresh_reg;
        result_next       = '0;
        result_valid_next = 1'b0;

        tbl_re    = 1'b0;
        tbl_raddr = '0;
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        cpu_re    = 1'b0;
        cpu_raddr = '0;
        cpu_we    = 1'b0;
        cpu_waddr = '0;
        cpu_wdata = '0;

        lvl     = '0;
        old     = '0;
        bit_sel = '0;
        irq     = '0;
        pend    = '0;
        wanted  = '0;
        tdata   = '0;
        rest    = '0;
        top     = '0;
        mw      = 1'b0;
        en      = 1'b0;
        fake    = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                lilm_pkg::CFG_OWNER_CPU: master_next = cfg_data[1:0];
                lilm_pkg::CFG_THRESHOLD: thresh_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    item_next = item;
                    case (item.cmd)
                        lilm_pkg::CMD_SET_LEVEL:
                        begin
                            if (int'(item.cpu_index) >= NUM_CPUS) begin
                                // unknown processor: bare reply
                                result_next.kind  = lilm_pkg::KIND_LEVEL;
                                result_next.last  = 1'b1;
                                result_valid_next = 1'b1;
                            end else begin
                                cpu_re     = 1'b1;
                                cpu_raddr  = CPU_W'(item.cpu_index);
                                state_next = S_LV_RD;
                            end
                        end
                        lilm_pkg::CMD_INTERRUPT:
                        begin
                            irq  = item.hw_word | pending_reg;
                            pend = pending_reg;
                            if ((item.hw_word & ~desired_reg) != '0) begin
                                // lazy mask: hardware catches up with desired mask
                                current_next = desired_reg;
                                mw           = 1'b1;
                                pend         = pending_reg | irq;
                            end
                            wanted       = irq & desired_reg;
                            pending_next = pend & ~wanted;
                            irq_next     = wanted;
                            result_next.kind        = lilm_pkg::KIND_ACK;
                            result_next.mask_write  = mw;
                            result_next.mask_value  = mw ? desired_reg : '0;
                            result_next.clear_value = item.hw_word;
                            result_next.last        = (wanted == '0);
                            result_valid_next       = 1'b1;
                            if (wanted != '0) begin
                                state_next = S_DISP;
                            end
                        end
                        lilm_pkg::CMD_REGISTER:
                        begin
                            lvl     = clamp_level(item.new_level);
                            bit_sel = NL'(1) << item.line_index;
                            result_next.kind  = lilm_pkg::KIND_REGISTER;
                            result_next.last  = 1'b1;
                            if (int'(item.line_index) >= NL ||
                                (line_taken_reg & bit_sel) != '0) begin
                                result_next.status = 1'b1;
                                result_valid_next  = 1'b1;
                            end else begin
                                line_taken_next = line_taken_reg | bit_sel;
                                lvl_next        = lvl;
                                if (int'(lvl) >= NUM_LEVELS - 1) begin
                                    result_valid_next = 1'b1;
                                end else begin
                                    // sweep from the top level down
                                    tbl_re     = 1'b1;
                                    tbl_raddr  = TOP_LEVEL;
                                    addr_next  = TOP_LEVEL;
                                    state_next = S_REG_WR;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LV_RD:
            begin
                old = cpu_vld_reg[CPU_W'(item_reg.cpu_index)] ? cpu_rdata : '0;
                lvl = clamp_level(item_reg.new_level);
                if (!item_reg.lowering && lvl > old) begin
                    lvl = old;
                end
                cpu_we    = 1'b1;
                cpu_waddr = CPU_W'(item_reg.cpu_index);
                cpu_wdata = lvl;
                cpu_vld_next[CPU_W'(item_reg.cpu_index)] = 1'b1;
                oldl_next  = old;
                lvl_next   = lvl;
                tbl_re     = 1'b1;
                tbl_raddr  = LVL_W'(lvl);
                state_next = S_LV_TBL;
            end
            S_LV_TBL:
            begin
                tdata = tbl_vld_reg[LVL_W'(lvl_reg)] ? tbl_rdata : '0;
                en    = (lvl_reg > thresh_reg);
                if (item_reg.cpu_index == master_reg && en) begin
                    desired_next = tdata;
                    if (oldl_reg < lvl_reg) begin
                        if ((current_reg & tdata) != tdata) begin
                            current_next = tdata;
                            mw           = 1'b1;
                        end
                        pending_next = pending_reg | item_reg.hw_word;
                        fake = ((pending_reg | item_reg.hw_word) & tdata) != '0;
                    end
                end
                result_next.kind           = lilm_pkg::KIND_LEVEL;
                result_next.prev_level     = oldl_reg;
                result_next.cpu_int_enable = en;
                result_next.fake_interrupt = fake;
                result_next.mask_write     = mw;
                result_next.mask_value     = mw ? tdata : '0;
                result_next.last           = 1'b1;
                result_valid_next          = 1'b1;
                state_next                 = S_IDLE;
            end
            S_REG_WR:
            begin
                bit_sel   = NL'(1) << item_reg.line_index;
                tdata     = tbl_vld_reg[addr_reg] ? tbl_rdata : '0;
                tbl_we    = 1'b1;
                tbl_waddr = addr_reg;
                tbl_wdata = tdata | bit_sel;
                tbl_vld_next[addr_reg] = 1'b1;
                if (int'(addr_reg) > int'(lvl_reg) + 1) begin
                    addr_next = addr_reg - LVL_W'(1);
                    tbl_re    = 1'b1;
                    tbl_raddr = addr_reg - LVL_W'(1);
                end else begin
                    result_next.kind  = lilm_pkg::KIND_REGISTER;
                    result_next.last  = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_DISP:
            begin
                top  = top_bit(irq_reg);
                rest = irq_reg & ~(NL'(1) << top);
                result_next.kind            = lilm_pkg::KIND_DISPATCH;
                result_next.dispatch_line   = top;
                result_next.line_registered = line_taken_reg[top];
                result_next.last            = (rest == '0);
                result_valid_next           = 1'b1;
                irq_next                    = rest;
                if (rest == '0) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            item_reg         <= '0;
            oldl_reg         <= '0;
            lvl_reg          <= '0;
            addr_reg         <= '0;
            irq_reg          <= '0;
            line_taken_reg   <= '0;
            pending_reg      <= '0;
            desired_reg      <= '0;
            current_reg      <= '0;
            tbl_vld_reg      <= '0;
            cpu_vld_reg      <= '0;
            master_reg       <= '0;
            thresh_reg       <= lilm_pkg::THRESHOLD_RESET;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            oldl_reg         <= oldl_next;
            lvl_reg          <= lvl_next;
            addr_reg         <= addr_next;
            irq_reg          <= irq_next;
            line_taken_reg   <= line_taken_next;
            pending_reg      <= pending_next;
            desired_reg      <= desired_next;
            current_reg      <= current_next;
            tbl_vld_reg      <= tbl_vld_next;
            cpu_vld_reg      <= cpu_vld_next;
            master_reg       <= master_next;
            thresh_reg       <= thresh_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // level mask memory
    always_ff @(posedge clk)
    begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rdata <= tbl_mem[tbl_raddr];
        end
    end

    // processor level memory
    always_ff @(posedge clk)
    begin
        if (cpu_we) begin
            cpu_mem[cpu_waddr] <= cpu_wdata;
        end
        if (cpu_re) begin
            cpu_rdata <= cpu_mem[cpu_raddr];
        end
    end

    // registered lines are never released
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_taken_reg & $past(line_taken_reg)) == $past(line_taken_reg))
        else $error("line_taken lost a bit");

    // hardware mask only ever moves to the desired mask
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(current_reg) |-> current_reg == desired_reg)
        else $error("current mask diverged from desired mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DISP |-> irq_reg != '0)
        else $error("dispatch with no wanted lines");

    // final transfer of a command leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.last |-> state_reg == S_IDLE)
        else $error("last result while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.last |-> state_reg == S_DISP)
        else $error("non-final result outside dispatch");

endmodule

// ===== dv/tb_lazy_interrupt_level_masker_core.sv =====
module tb_lazy_interrupt_level_masker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS    = 8;
    localparam int NUM_CPUS      = 4;
    // quiet margin after the last result before the configuration changes
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 72;

    // the fourth command code is accepted and dropped without a result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Scoreboard: mirrors the masker state, queues expected results per
    // accepted command and checks each observed result against the oldest one.
    class masker_scoreboard;
        logic [31:0]                    level_mask [NUM_LEVELS];
        logic [lilm_pkg::LEVEL_W-1:0]   cpu_level [NUM_CPUS];
        logic [31:0]                    taken_lines;
        logic [31:0]                    pending_lines;
        logic [31:0]                    desired_mask;
        logic [31:0]                    hw_mask;
        logic [lilm_pkg::CPU_IDX_W-1:0] owner_cpu;
        logic [lilm_pkg::LEVEL_W-1:0]   threshold;
        lilm_pkg::result_t              expected_results [$];
        int                             errors;

        function new();
            foreach (level_mask[i]) level_mask[i] = '0;
            foreach (cpu_level[i]) cpu_level[i] = '0;
            taken_lines   = '0;
            pending_lines = '0;
            desired_mask  = '0;
            hw_mask       = '0;
            owner_cpu     = '0;
            threshold     = lilm_pkg::THRESHOLD_RESET;
            errors        = 0;
        endfunction

        function void write_reg(logic [lilm_pkg::CFG_IDX_W-1:0] idx,
                                logic [lilm_pkg::CFG_DATA_W-1:0] data);
            if (idx == lilm_pkg::CFG_OWNER_CPU)
                owner_cpu = data[lilm_pkg::CPU_IDX_W-1:0];
            else if (idx == lilm_pkg::CFG_THRESHOLD)
                threshold = data[lilm_pkg::LEVEL_W-1:0];
        endfunction

        function void note_item(lilm_pkg::item_t it);
            lilm_pkg::result_t            r;
            logic [lilm_pkg::LEVEL_W-1:0] lvl;
            logic [lilm_pkg::LEVEL_W-1:0] prev;
            logic [31:0]                  irq;
            int                           b;
            r   = '0;
            lvl = it.new_level;
            case (it.cmd)
                lilm_pkg::CMD_SET_LEVEL:
                begin
                    prev = cpu_level[it.cpu_index];
                    // opening needs the lowering flag, closing is always allowed
                    if (!it.lowering && lvl > prev)
                        lvl = prev;
                    cpu_level[it.cpu_index] = lvl;
                    r.kind           = lilm_pkg::KIND_LEVEL;
                    r.prev_level     = prev;
                    r.cpu_int_enable = lvl > threshold;
                    if (it.cpu_index == owner_cpu && r.cpu_int_enable)
                    begin
                        desired_mask = level_mask[lvl];
                        if (prev < lvl)
                        begin
                            if ((hw_mask & desired_mask) != desired_mask)
                            begin
                                hw_mask      = desired_mask;
                                r.mask_write = 1'b1;
                                r.mask_value = hw_mask;
                            end
                            pending_lines   |= it.hw_word;
                            r.fake_interrupt = (pending_lines & desired_mask) != 0;
                        end
                    end
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
                lilm_pkg::CMD_INTERRUPT:
                begin
                    irq           = it.hw_word | pending_lines;
                    r.kind        = lilm_pkg::KIND_ACK;
                    r.clear_value = it.hw_word;
                    // unwanted event: tighten the hardware mask, keep it pending
                    if ((it.hw_word & ~desired_mask) != 0)
                    begin
                        hw_mask        = desired_mask;
                        r.mask_write   = 1'b1;
                        r.mask_value   = hw_mask;
                        pending_lines |= irq;
                    end
                    irq           &= desired_mask;
                    pending_lines &= ~irq;
                    r.last         = (irq == 0);
                    expected_results.push_back(r);
                    for (b = 31; b >= 0; b--)
                    begin
                        if (irq[b])
                        begin
                            irq[b]            = 1'b0;
                            r                 = '0;
                            r.kind            = lilm_pkg::KIND_DISPATCH;
                            r.dispatch_line   = b[lilm_pkg::LINE_W-1:0];
                            r.line_registered = taken_lines[b];
                            r.last            = (irq == 0);
                            expected_results.push_back(r);
                        end
                    end
                end
                lilm_pkg::CMD_REGISTER:
                begin
                    r.kind = lilm_pkg::KIND_REGISTER;
                    r.last = 1'b1;
                    if (taken_lines[it.line_index])
                        r.status = 1'b1;
                    else
                    begin
                        taken_lines[it.line_index] = 1'b1;
                        for (b = NUM_LEVELS - 1; b > int'(lvl); b--)
                            level_mask[b][it.line_index] = 1'b1;
                    end
                    expected_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(lilm_pkg::result_t got);
            lilm_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (want !== got)
            begin
                $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            start     = 1'b0;
    lilm_pkg::item_t                 item      = '0;
    logic                            cfg_valid = 1'b0;
    logic [lilm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lilm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            busy;
    logic                            result_valid;
    lilm_pkg::result_t               result;
    logic                            cfg_ready;

    int                              cycle_count = 0;
    masker_scoreboard                sb;

    lazy_interrupt_level_masker_core #(
        .NUM_LEVELS(NUM_LEVELS),
        .NUM_CPUS  (NUM_CPUS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing result ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Results cannot be held off, so every strobed cycle is one transfer.
    // Sampled at the edge: values are the ones held during the ending cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    function automatic lilm_pkg::item_t make_item(logic [1:0] cmd,
                                                  logic [lilm_pkg::CPU_IDX_W-1:0] cpu,
                                                  logic [lilm_pkg::LEVEL_W-1:0] lvl,
                                                  logic low, logic [31:0] hw,
                                                  logic [lilm_pkg::LINE_W-1:0] line);
        lilm_pkg::item_t it;
        it.cmd        = cmd;
        it.cpu_index  = cpu;
        it.new_level  = lvl;
        it.lowering   = low;
        it.hw_word    = hw;
        it.line_index = line;
        return it;
    endfunction

    // Random command mix. Set-level mostly targets the master CPU so that the
    // mask and pending logic is exercised; interrupts use sparse and dense
    // event words so dispatch bursts vary from none to all 32 lines.
    function automatic lilm_pkg::item_t random_item();
        lilm_pkg::item_t it;
        logic [63:0]     rnd;
        int              pick;
        rnd           = {$urandom, $urandom};
        it            = rnd[$bits(lilm_pkg::item_t)-1:0];
        it.hw_word    = $urandom;
        pick          = $urandom_range(0, 99);
        if (pick < 8)
            it.cmd = lilm_pkg::CMD_REGISTER;
        else if (pick < 12)
            it.cmd = CMD_UNUSED;
        else if (pick < 45)
        begin
            it.cmd = lilm_pkg::CMD_SET_LEVEL;
            if ($urandom_range(0, 9) < 7)
                it.cpu_index = sb.owner_cpu;
            it.lowering = ($urandom_range(0, 9) < 6);
            if ($urandom_range(0, 1) == 0)
                it.hw_word = $urandom & $urandom;
        end
        else
        begin
            it.cmd = lilm_pkg::CMD_INTERRUPT;
            case ($urandom_range(0, 3))
                0:       it.hw_word = '0;
                1:       it.hw_word = $urandom & $urandom & $urandom;
                2:       it.hw_word = $urandom & $urandom;
                default: ;
            endcase
        end
        return it;
    endfunction

    // Drop start only if it is up; never touched twice in one step.
    task automatic release_start();
        if (start)
            start <= 1'b0;
    endtask

    // Present one command and hold it until the transfer edge (start & !busy).
    task automatic send_cmd(input lilm_pkg::item_t it);
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic stall(input int cycles);
        release_start();
        repeat (cycles) @(posedge clk);
    endtask

    // Sender holds off until every expected result has come back.
    task automatic drain();
        release_start();
        do
            @(posedge clk);
        while (sb.expected_results.size() != 0);
    endtask

    // Full quiesce: an unused or no-sweep command may still be in flight.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [lilm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lilm_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [lilm_pkg::CPU_IDX_W-1:0] master,
                              input logic [lilm_pkg::LEVEL_W-1:0] thr);
        write_cfg(lilm_pkg::CFG_OWNER_CPU, lilm_pkg::CFG_DATA_W'(master));
        write_cfg(lilm_pkg::CFG_THRESHOLD, lilm_pkg::CFG_DATA_W'(thr));
        cfg_valid <= 1'b0;
    endtask

    // One random phase. Idling comes in bursts; some 16-command stretches run
    // back to back. Halfway through, the sender waits for a full drain.
    task automatic run_phase(input int count, input bit idling);
        lilm_pkg::item_t it;
        int              done;
        bit              quiet;
        bit              paused;
        done   = 0;
        quiet  = 1'b0;
        paused = 1'b0;
        while (done < count)
        begin
            if (done % 16 == 0)
                quiet = !idling || ($urandom_range(0, 2) == 0);
            if (done == count / 2 && !paused)
            begin
                paused = 1'b1;
                drain();
            end
            it = random_item();
            send_cmd(it);
            if (it.cmd != CMD_UNUSED)
                done++;
            if (!quiet && $urandom_range(0, 2) == 0)
                stall($urandom_range(1, 19));
        end
    endtask

    initial
    begin
        lilm_pkg::item_t directed [$];
        int              p;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset config (master 0, threshold 2).
        // interrupt with nothing wanted or pending: lone acknowledge with last
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 0, 0, 0, 32'h0, 0));
        // registrations: lowest level, highest level (no entry swept), duplicate
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 0, 0, 32'h0, 0));
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 7, 0, 32'h0, 31));
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 3, 0, 32'h0, 5));
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 1, 0, 32'h0, 5));
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 6, 0, 32'h0, 17));
        // raise without the lowering flag is refused, then allowed
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 0, 7, 0, 32'hFFFF_FFFF, 0));
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 0, 7, 1, 32'hFFFF_FFFF, 0));
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 0, 0, 0, 32'h0, 0));
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 0, 0, 0, 32'hFFFF_FFFF, 0));
        // close down, then events on unwanted lines are masked lazily
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 0, 3, 0, 32'h0, 0));
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 0, 0, 0, 32'h8000_0021, 0));
        // non-master request only moves that CPU's level
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 2, 5, 1, 32'h0000_FFFF, 0));
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 0, 6, 1, 32'h0002_0000, 0));
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 0, 0, 0, 32'h0, 0));
        directed.push_back(make_item(CMD_UNUSED, 3, 7, 1, 32'hFFFF_FFFF, 31));
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 0, 0, 1, 32'h0, 0));
        // interrupt fields other than the event word are don't-care
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 3, 7, 1, 32'hAAAA_5555, 0));
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 1, 7, 1, 32'h0, 0));
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 3, 7, 1, 32'hFFFF_FFFF, 0));
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 0, 0, 32'h0, 31));
        directed.push_back(make_item(lilm_pkg::CMD_SET_LEVEL, 0, 7, 1, 32'h0, 0));
        directed.push_back(make_item(lilm_pkg::CMD_INTERRUPT, 0, 0, 0, 32'h0000_0001, 0));
        directed.push_back(make_item(lilm_pkg::CMD_REGISTER, 0, 2, 0, 32'h0, 9));
        foreach (directed[i])
        begin
            send_cmd(directed[i]);
            if ($urandom_range(0, 1) == 0)
                stall($urandom_range(1, 19));
        end

        // Random phases, each under its own config; the extremes come first
        // and the last phase runs with no idling at all.
        for (p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0:       set_config(2'd3, 3'd7);
                1:       set_config(2'd1, 3'd0);
                2:       set_config(2'd2, 3'($urandom_range(1, 6)));
                5:       set_config(2'd0, 3'd0);
                default: set_config(2'($urandom), 3'($urandom));
            endcase
            run_phase(PHASE_ITEMS, p != 5);
        end

        settle();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
